/* hw/rtl/rbc_pkg.sv */
// ----------------------------------------------------------------------------
// Range background classifier package
// Shared types and constants for the range background classifier.
// ----------------------------------------------------------------------------
package rbc_pkg;

  localparam int ANGLE_W = 16;
  localparam int DIST_W  = 16;
  localparam int CFG_W   = 16;
  localparam int REG_IDX_W = 1;

  localparam int DEFAULT_BINS = 1024;

  localparam logic [DIST_W-1:0] NO_BACKGROUND = 16'hFFFF;
  localparam logic [CFG_W-1:0]  LEARN_FRAMES_RESET = 16'd100;
  localparam logic [CFG_W-1:0]  MARGIN_RESET = 16'd100;

  localparam logic [REG_IDX_W-1:0] REG_LEARN_FRAMES = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MARGIN       = 1'b1;

  typedef enum logic [0:0] {
    OP_LEARN    = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

endpackage

/* hw/rtl/range_background_classifier.sv */
// ----------------------------------------------------------------------------
// Range background classifier
// Learns the nearest range seen per angle bin and flags points nearer by more than the margin.
//
// Channel  | Direction | Handshake                  | Payload
// item     | in        | item_valid / item_stall     | operation, point_angle,
//          |           |                            | point_distance, frame_end
// result   | out       | result_valid / result_stall | foreground, still_learning
// config   | in        | write_enable               | register_index, write_data
//
// One transaction is accepted per cycle while item_stall is low. The bin store
// is read at acceptance (three reads served by two copies of the store) into
// the stage registers; the store is updated and the result registered when
// that stage advances. After reset a clearing pass fills the store with the
// no-background value; item_stall is high during that pass.
// A stalled result holds the result register, and item_stall rises once the
// stage behind it is also full.
// ----------------------------------------------------------------------------
module range_background_classifier
  import rbc_pkg::*;
#(
  parameter int BINS = DEFAULT_BINS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic                 operation,
  input  logic [ANGLE_W-1:0]   point_angle,
  input  logic [DIST_W-1:0]    point_distance,
  input  logic                 frame_end,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 foreground,
  output logic                 still_learning,
  input  logic                 write_enable,
  input  logic [REG_IDX_W-1:0] register_index,
  input  logic [CFG_W-1:0]     write_data
);

  localparam int BIN_W = (BINS > 1) ? $clog2(BINS) : 1;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS - 1);
  localparam logic [ANGLE_W:0] BINS_V = (ANGLE_W + 1)'(BINS);

  logic [CFG_W-1:0]  learn_frames;
  logic [CFG_W-1:0]  margin;
  logic [CFG_W-1:0]  frames_seen;
  logic [CFG_W-1:0]  frames_seen_next;

  logic              clearing;
  logic [BIN_W-1:0]  clear_cnt;

  logic [DIST_W-1:0] mem_a [BINS];
  logic [DIST_W-1:0] mem_b [BINS];

  logic              wr_en;
  logic [BIN_W-1:0]  wr_addr;
  logic [DIST_W-1:0] wr_data;

  logic [2*ANGLE_W:0] angle_product;
  logic [BIN_W-1:0]   in_bin;
  logic [BIN_W-1:0]   in_up;
  logic [BIN_W-1:0]   in_down;
  logic               item_fire;

  logic              s1_valid;
  op_t               s1_op;
  logic [DIST_W-1:0] s1_dist;
  logic              s1_fend;
  logic [BIN_W-1:0]  s1_bin;
  logic [DIST_W-1:0] rd_center;
  logic [DIST_W-1:0] rd_up;
  logic [DIST_W-1:0] rd_down;
  logic              s1_fire;
  logic              out_free;

  logic              learning;
  logic              learn_item;
  logic              learn_write;
  logic [DIST_W-1:0] bg_pair;
  logic [DIST_W-1:0] bg_min;
  logic [DIST_W:0]   dist_sum;
  logic              fg_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_frames <= LEARN_FRAMES_RESET;
      margin <= MARGIN_RESET;
    end else if (write_enable) begin
      unique case (register_index)
        REG_LEARN_FRAMES: learn_frames <= write_data;
        REG_MARGIN:       margin <= write_data;
        default: ;
      endcase
    end
  end

  // Bin lookup and wrap-around neighbors of the incoming point.
  assign angle_product = {{(ANGLE_W + 1){1'b0}}, point_angle} * {{ANGLE_W{1'b0}}, BINS_V};
  assign in_bin  = angle_product[BIN_W+ANGLE_W-1:ANGLE_W];
  assign in_up   = (in_bin == LAST_BIN) ? '0 : in_bin + BIN_W'(1);
  assign in_down = (in_bin == '0) ? LAST_BIN : in_bin - BIN_W'(1);

  assign out_free   = !result_valid || !result_stall;
  assign s1_fire    = s1_valid && out_free;
  assign item_stall = clearing || (s1_valid && !out_free);
  assign item_fire  = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clear_cnt <= '0;
    end else if (clearing) begin
      if (clear_cnt == LAST_BIN) begin
        clearing <= 1'b0;
      end
      clear_cnt <= clear_cnt + BIN_W'(1);
    end
  end

  always_comb begin
    if (clearing) begin
      wr_en = 1'b1;
      wr_addr = clear_cnt;
      wr_data = NO_BACKGROUND;
    end else begin
      wr_en = s1_fire && learn_write;
      wr_addr = s1_bin;
      wr_data = s1_dist;
    end
  end

  // Two copies of the store give three read ports; a write in the same
  // cycle as a read of the same bin is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
      mem_b[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      rd_center <= (wr_en && wr_addr == in_bin) ? wr_data : mem_a[in_bin];
      rd_up <= (wr_en && wr_addr == in_up) ? wr_data : mem_a[in_up];
      rd_down <= (wr_en && wr_addr == in_down) ? wr_data : mem_b[in_down];
      s1_op <= op_t'(operation);
      s1_dist <= point_distance;
      s1_fend <= frame_end;
      s1_bin <= in_bin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_comb begin
    learning = frames_seen < learn_frames;
    learn_item = (s1_op == OP_LEARN) && learning;
    learn_write = learn_item && (s1_dist != '0) && (s1_dist < rd_center);
    frames_seen_next = frames_seen + CFG_W'(learn_item && s1_fend);
    bg_pair = (rd_up < rd_center) ? rd_up : rd_center;
    bg_min = (rd_down < bg_pair) ? rd_down : bg_pair;
    dist_sum = {1'b0, s1_dist} + {1'b0, margin};
    fg_value = (s1_op == OP_CLASSIFY) && (s1_dist != '0)
               && ((bg_min == NO_BACKGROUND) || (dist_sum < {1'b0, bg_min}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_seen <= '0;
    end else if (s1_fire) begin
      frames_seen <= frames_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      foreground <= fg_value;
      still_learning <= frames_seen_next < learn_frames;
    end
  end

  // The frame count only ever advances by one.
  assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (frames_seen == $past(frames_seen))
                    || (frames_seen == $past(frames_seen) + CFG_W'(1)))
    else $error("frame count changed by more than one");

  // No transaction is in flight during the clearing pass.
  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !result_valid)
    else $error("transaction in flight while clearing");

  // A learned minimum is never the no-background value and always lowers the bin minimum.
  assert property (@(posedge clk) disable iff (rst)
    (wr_en && !clearing) |-> (wr_data != NO_BACKGROUND) && (wr_data < rd_center))
    else $error("learn write does not lower the bin minimum");

  // A result waiting on a stall blocks the stage behind it from advancing.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && result_valid && result_stall) |=> s1_valid)
    else $error("stage lost while result stalled");

endmodule
